### src/bls_pkg.sv
// ----------------------------------------------------------------------------
// Bounded LIFO stack package
// Shared constants and control types for the stack controller and datapath.
// ----------------------------------------------------------------------------
package bls_pkg;

  // Default number of words the stack holds.
  localparam int unsigned DEFAULT_DEPTH = 128;

  // Field widths fixed by the item format.
  localparam int unsigned CMD_W    = 2;
  localparam int unsigned WORD_W   = 32;
  localparam int unsigned STATUS_W = 2;

  // Operation codes.
  localparam logic [CMD_W-1:0] CMD_PUSH = 2'd0;
  localparam logic [CMD_W-1:0] CMD_POP  = 2'd1;
  localparam logic [CMD_W-1:0] CMD_PEEK = 2'd2;

  // Result status codes.
  localparam logic [STATUS_W-1:0] ST_OK        = 2'd0;
  localparam logic [STATUS_W-1:0] ST_OVERFLOW  = 2'd1;
  localparam logic [STATUS_W-1:0] ST_UNDERFLOW = 2'd2;

  // Word returned by a pop or peek on an empty stack.
  localparam logic [WORD_W-1:0] UNDERFLOW_WORD = '1;

  // Commands from the controller to the datapath.
  typedef struct packed {
    logic accept;       // Input item taken this cycle.
    logic load_direct;  // Load the result computed from the item itself.
    logic load_read;    // Load the result from the registered memory read.
  } ctrl_cmd_t;

  // Status from the datapath to the controller.
  typedef struct packed {
    logic read_needed;  // The offered item is a pop or peek on a non-empty stack.
  } dp_status_t;

endpackage

### src/bls_datapath.sv
// ----------------------------------------------------------------------------
// Bounded LIFO stack datapath
// Word memory, fill counter, registered read port and result register.
// ----------------------------------------------------------------------------
module bls_datapath #(
  parameter int unsigned DEPTH = bls_pkg::DEFAULT_DEPTH
) (
  input  logic                              clk,
  input  logic                              rst,
  input  bls_pkg::ctrl_cmd_t                ctrl,
  output bls_pkg::dp_status_t               stat,
  input  logic [bls_pkg::CMD_W-1:0]         cmd,
  input  logic signed [bls_pkg::WORD_W-1:0] push_word,
  output logic signed [bls_pkg::WORD_W-1:0] out_word,
  output logic [bls_pkg::STATUS_W-1:0]      status,
  output logic                              is_empty,
  output logic                              is_full
);

  localparam int unsigned AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int unsigned CW = $clog2(DEPTH + 1);

  logic [bls_pkg::WORD_W-1:0] mem [DEPTH];
  logic [bls_pkg::WORD_W-1:0] rd_data;
  logic [CW-1:0]              count;
  logic [CW-1:0]              count_next;
  logic [CW-1:0]              top;
  logic                       now_empty;
  logic                       now_full;
  logic                       is_push;
  logic                       is_pop;
  logic                       is_read_cmd;
  logic                       do_write;
  logic [bls_pkg::WORD_W-1:0] word_d;
  logic [bls_pkg::STATUS_W-1:0] status_d;

  // Decode the offered item against the current fill.
  assign now_empty   = (count == '0);
  assign now_full    = (count == CW'(DEPTH));
  assign top         = count - CW'(1);
  assign is_push     = (cmd == bls_pkg::CMD_PUSH);
  assign is_pop      = (cmd == bls_pkg::CMD_POP);
  assign is_read_cmd = is_pop || (cmd == bls_pkg::CMD_PEEK);
  assign do_write    = ctrl.accept && is_push && !now_full;

  assign stat.read_needed = is_read_cmd && !now_empty;

  // Fill count after this cycle's operation.
  always_comb begin
    count_next = count;
    if (do_write) begin
      count_next = count + CW'(1);
    end else if (ctrl.accept && is_pop && !now_empty) begin
      count_next = top;
    end
  end

  // Result of items that need no memory read.
  always_comb begin
    word_d   = '0;
    status_d = bls_pkg::ST_OK;
    if (is_push) begin
      word_d = push_word;
      if (now_full) begin
        status_d = bls_pkg::ST_OVERFLOW;
      end
    end else if (is_read_cmd) begin
      word_d   = bls_pkg::UNDERFLOW_WORD;
      status_d = bls_pkg::ST_UNDERFLOW;
    end
  end

  // Fill counter.
  always_ff @(posedge clk) begin
    if (rst) begin
      count <= '0;
    end else begin
      count <= count_next;
    end
  end

  // Word memory with one write port and a registered read port.
  always_ff @(posedge clk) begin
    if (do_write) begin
      mem[count[AW-1:0]] <= push_word;
    end
    if (ctrl.accept && stat.read_needed) begin
      rd_data <= mem[top[AW-1:0]];
    end
  end

  // Result register; the flags reflect the fill after the operation.
  always_ff @(posedge clk) begin
    if (ctrl.load_direct) begin
      out_word <= word_d;
      status   <= status_d;
    end else if (ctrl.load_read) begin
      out_word <= rd_data;
      status   <= bls_pkg::ST_OK;
    end
    if (ctrl.load_direct || ctrl.load_read) begin
      is_empty <= (count_next == '0);
      is_full  <= (count_next == CW'(DEPTH));
    end
  end

endmodule

### src/bls_controller.sv
// ----------------------------------------------------------------------------
// Bounded LIFO stack controller
// Sequences item acceptance, memory reads and the result handshake.
// ----------------------------------------------------------------------------
module bls_controller (
  input  logic                clk,
  input  logic                rst,
  input  logic                in_valid,
  output logic                in_stall,
  output logic                out_valid,
  input  logic                out_stall,
  output bls_pkg::ctrl_cmd_t  ctrl,
  input  bls_pkg::dp_status_t stat
);

  typedef enum logic [1:0] {
    S_IDLE = 2'b01,
    S_READ = 2'b10
  } state_t;

  state_t state;
  state_t state_next;
  logic   slot_free;
  logic   load;

  // The result register can take a new result when empty or being emptied.
  // No item is taken while reset is held.
  assign slot_free = !out_valid || !out_stall;
  assign in_stall  = rst || !((state == S_IDLE) && slot_free);

  assign ctrl.accept      = in_valid && !in_stall;
  assign ctrl.load_direct = ctrl.accept && !stat.read_needed;
  assign ctrl.load_read   = (state == S_READ);
  assign load             = ctrl.load_direct || ctrl.load_read;

  // Next state: a pop or peek with data waits in S_READ for the registered memory read.
  always_comb begin
    state_next = state;
    case (state)
      S_IDLE: begin
        if (ctrl.accept && stat.read_needed) begin
          state_next = S_READ;
        end
      end
      S_READ: begin
        state_next = S_IDLE;
      end
      default: begin
        state_next = S_IDLE;
      end
    endcase
  end

  // State and result valid flag.
  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= S_IDLE;
      out_valid <= 1'b0;
    end else begin
      state <= state_next;
      if (load) begin
        out_valid <= 1'b1;
      end else if (!out_stall) begin
        out_valid <= 1'b0;
      end
    end
  end

endmodule

### src/bounded_lifo_stack_top.sv
// ----------------------------------------------------------------------------
// Bounded LIFO stack
// Fixed-depth stack of signed 32-bit words with push, pop and peek items.
// ----------------------------------------------------------------------------
// Usage:
// An item (cmd, push_word) is taken when in_valid is high and in_stall is low.
// Each item yields exactly one result (out_word, status, is_empty, is_full),
// delivered when out_valid is high and out_stall is low.
// A push, an underflowing pop or peek, and an unused command need no memory
// read: the result is valid the cycle after the item is taken.
// A pop or peek on a non-empty stack waits for the registered read port of
// the word memory; the next item is taken after that read.
// The result register holds a finished result while the receiver stalls, and
// a new item is taken in the same cycle the waiting result leaves.
// Reset empties the stack and drops any pending result; the memory contents
// need no clearing, since only words below the fill count are ever read.
// ----------------------------------------------------------------------------
module bounded_lifo_stack_top #(
  parameter int unsigned DEPTH = bls_pkg::DEFAULT_DEPTH
) (
  input  logic                              clk,
  input  logic                              rst,
  input  logic                              in_valid,
  output logic                              in_stall,
  input  logic [bls_pkg::CMD_W-1:0]         cmd,
  input  logic signed [bls_pkg::WORD_W-1:0] push_word,
  output logic                              out_valid,
  input  logic                              out_stall,
  output logic signed [bls_pkg::WORD_W-1:0] out_word,
  output logic [bls_pkg::STATUS_W-1:0]      status,
  output logic                              is_empty,
  output logic                              is_full
);

  bls_pkg::ctrl_cmd_t  ctrl;
  bls_pkg::dp_status_t stat;

  // Handshake and sequencing.
  bls_controller u_ctrl (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (in_valid),
    .in_stall  (in_stall),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .ctrl      (ctrl),
    .stat      (stat)
  );

  // Storage and result formation.
  bls_datapath #(
    .DEPTH (DEPTH)
  ) u_dp (
    .clk       (clk),
    .rst       (rst),
    .ctrl      (ctrl),
    .stat      (stat),
    .cmd       (cmd),
    .push_word (push_word),
    .out_word  (out_word),
    .status    (status),
    .is_empty  (is_empty),
    .is_full   (is_full)
  );

endmodule

### tb/tb_top.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// Bounded LIFO stack testbench
// Drives push, pop, peek and unused command items into the stack with random
// gaps and back-pressure. A shadow stack inside the bench predicts each
// result, and every result leaving the block is checked field by field.
// ----------------------------------------------------------------------------
module tb_top;

  import bls_pkg::*;

  localparam int unsigned STACK_DEPTH = DEFAULT_DEPTH;

  // Command code that the block treats as no operation.
  localparam logic [CMD_W-1:0] CMD_NOP = 2'd3;

  // Fields of one result item.
  typedef struct {
    logic signed [WORD_W-1:0] word;
    logic [STATUS_W-1:0]      stat;
    logic                     empty;
    logic                     full;
  } stack_result_t;

  logic                     clk = 1'b0;
  logic                     rst;
  logic                     in_valid;
  logic                     in_stall;
  logic [CMD_W-1:0]         cmd;
  logic signed [WORD_W-1:0] push_word;
  logic                     out_valid;
  logic                     out_stall;
  logic signed [WORD_W-1:0] out_word;
  logic [STATUS_W-1:0]      status;
  logic                     is_empty;
  logic                     is_full;

  // Shadow copy of the stack contents and fill level.
  logic signed [WORD_W-1:0] shadow_words [STACK_DEPTH];
  int unsigned              shadow_fill;

  // Results predicted for accepted items, oldest first.
  stack_result_t            pending_results [$];

  int unsigned              fail_count;
  int unsigned              lost_count;
  bit                       sender_idles;
  bit                       receiver_idles;
  // A long receiver hold-off is requested by bumping the serial number.
  int unsigned              hold_cycles;
  int unsigned              hold_serial;

  bounded_lifo_stack_top #(
    .DEPTH(STACK_DEPTH)
  ) uut (
    .clk(clk),
    .rst(rst),
    .in_valid(in_valid),
    .in_stall(in_stall),
    .cmd(cmd),
    .push_word(push_word),
    .out_valid(out_valid),
    .out_stall(out_stall),
    .out_word(out_word),
    .status(status),
    .is_empty(is_empty),
    .is_full(is_full)
  );

  // 20 ns clock.
  always begin
    #10 clk = 1'b1;
    #10 clk = 1'b0;
  end

  // Apply one command to the shadow stack and return the result it yields.
  function automatic stack_result_t stack_predict(input logic [CMD_W-1:0] c,
                                                  input logic signed [WORD_W-1:0] w);
    stack_result_t r;
    r.word = '0;
    r.stat = ST_OK;
    case (c)
      CMD_PUSH: begin
        r.word = w;
        if (shadow_fill >= STACK_DEPTH) begin
          r.stat = ST_OVERFLOW;
        end else begin
          shadow_words[shadow_fill] = w;
          shadow_fill++;
        end
      end
      CMD_POP, CMD_PEEK: begin
        if (shadow_fill == 0) begin
          r.stat = ST_UNDERFLOW;
          r.word = UNDERFLOW_WORD;
        end else begin
          r.word = shadow_words[shadow_fill - 1];
          if (c == CMD_POP) begin
            shadow_fill--;
          end
        end
      end
      default: begin
        // Unused code: the stack is left alone.
      end
    endcase
    r.empty = (shadow_fill == 0);
    r.full  = (shadow_fill >= STACK_DEPTH);
    return r;
  endfunction

  // Random word that lands on the extremes now and then.
  function automatic logic signed [WORD_W-1:0] pick_word();
    case ($urandom_range(0, 7))
      0: return 32'h7FFF_FFFF;
      1: return 32'h8000_0000;
      2: return '0;
      3: return '1;
      default: return $urandom;
    endcase
  endfunction

  // Offer one item, after a random gap when the sender idles, and hold it until the block takes it.
  task automatic send_item(input logic [CMD_W-1:0] c, input logic signed [WORD_W-1:0] w);
    int unsigned gap;
    gap = sender_idles ? $urandom_range(0, 5) : 0;
    repeat (gap) begin
      @(negedge clk);
      in_valid <= 1'b0;
    end
    @(negedge clk);
    in_valid  <= 1'b1;
    cmd       <= c;
    push_word <= w;
    do @(posedge clk); while (in_stall);
    pending_results.push_back(stack_predict(c, w));
  endtask

  // Stop offering items and wait until every predicted result has arrived.
  task automatic wait_drained();
    int unsigned cycles;
    cycles = 0;
    @(negedge clk);
    in_valid <= 1'b0;
    while (pending_results.size() != 0 && cycles < 20000) begin
      @(posedge clk);
      cycles++;
    end
    if (pending_results.size() != 0) begin
      $error("%0d results never arrived", pending_results.size());
      lost_count++;
    end
  endtask

  // Receiver: random stall stretches, or a long hold-off when one is requested.
  initial begin : drain_results
    int unsigned stall_n;
    int unsigned hold_seen;
    out_stall = 1'b0;
    hold_seen = 0;
    forever begin
      if (hold_serial != hold_seen) begin
        stall_n   = hold_cycles;
        hold_seen = hold_serial;
      end else begin
        stall_n = receiver_idles ? $urandom_range(0, 5) : 0;
      end
      @(negedge clk);
      if (stall_n > 0) begin
        out_stall <= 1'b1;
        repeat (stall_n) @(negedge clk);
      end
      out_stall <= 1'b0;
      do @(posedge clk); while (!(out_valid && !out_stall));
    end
  end

  // Compare each accepted result with the oldest prediction.
  always @(posedge clk) begin : check_results
    stack_result_t exp_r;
    if (!rst && out_valid && !out_stall) begin
      if (pending_results.size() == 0) begin
        $error("result with nothing expected: out_word %0d status %0d", out_word, status);
        fail_count++;
      end else begin
        exp_r = pending_results.pop_front();
        if (out_word !== exp_r.word) begin
          $error("out_word: expected %0d, got %0d", exp_r.word, out_word);
          fail_count++;
        end
        if (status !== exp_r.stat) begin
          $error("status: expected %0d, got %0d", exp_r.stat, status);
          fail_count++;
        end
        if (is_empty !== exp_r.empty) begin
          $error("is_empty: expected %0b, got %0b", exp_r.empty, is_empty);
          fail_count++;
        end
        if (is_full !== exp_r.full) begin
          $error("is_full: expected %0b, got %0b", exp_r.full, is_full);
          fail_count++;
        end
      end
    end
  end

  // Underflow on the empty stack, extreme words, the unused code, then drain.
  task automatic test_directed();
    send_item(CMD_POP, 32'h1234_5678);
    send_item(CMD_PEEK, '0);
    send_item(CMD_NOP, '1);
    send_item(CMD_PUSH, 32'h7FFF_FFFF);
    send_item(CMD_PEEK, '0);
    send_item(CMD_PUSH, 32'h8000_0000);
    send_item(CMD_PUSH, '0);
    send_item(CMD_PUSH, '1);
    send_item(CMD_PUSH, 32'h5555_5555);
    send_item(CMD_PUSH, 32'hAAAA_AAAA);
    send_item(CMD_NOP, 32'hDEAD_BEEF);
    send_item(CMD_PEEK, '1);
    repeat (6) send_item(CMD_POP, $urandom);
    send_item(CMD_POP, '0);
    send_item(CMD_PEEK, '0);
    send_item(CMD_NOP, '0);
  endtask

  // Fill to the top, push into the full stack, then pop back past empty.
  task automatic test_fill_and_drain();
    while (shadow_fill < STACK_DEPTH) begin
      send_item(CMD_PUSH, pick_word());
    end
    send_item(CMD_PUSH, 32'h7FFF_FFFF);
    send_item(CMD_PUSH, 32'h8000_0000);
    send_item(CMD_NOP, pick_word());
    send_item(CMD_PEEK, pick_word());
    while (shadow_fill > 0) begin
      if ($urandom_range(0, 9) == 0) begin
        send_item(CMD_PEEK, pick_word());
      end
      send_item(CMD_POP, pick_word());
    end
    send_item(CMD_POP, pick_word());
    send_item(CMD_PEEK, pick_word());
  endtask

  // Receiver holds off while items keep coming, then the sender waits it out.
  task automatic test_backpressure();
    hold_cycles = 300;
    hold_serial++;
    repeat (40) send_item(($urandom_range(0, 2) == 0) ? CMD_PEEK : CMD_PUSH, pick_word());
    wait_drained();
    repeat (40) send_item(CMD_PUSH + CMD_W'($urandom_range(0, 3)), pick_word());
    wait_drained();
  endtask

  // Random walk whose push share changes per stretch to visit empty and full.
  task automatic test_random_walk(input int unsigned n_items);
    int unsigned push_pct;
    int unsigned r;
    logic [CMD_W-1:0] c;
    push_pct = 50;
    for (int unsigned i = 0; i < n_items; i++) begin
      if (i % 150 == 0) begin
        case ($urandom_range(0, 2))
          0: push_pct = 20;
          1: push_pct = 50;
          default: push_pct = 85;
        endcase
        sender_idles   = ($urandom_range(0, 3) != 0);
        receiver_idles = ($urandom_range(0, 3) != 0);
      end
      r = $urandom_range(0, 99);
      if (r < 4) begin
        c = CMD_NOP;
      end else if (r < push_pct) begin
        c = CMD_PUSH;
      end else if (r < push_pct + (100 - push_pct) / 2) begin
        c = CMD_POP;
      end else begin
        c = CMD_PEEK;
      end
      send_item(c, pick_word());
    end
  endtask

  // Test sequence.
  initial begin
    rst            = 1'b1;
    in_valid       = 1'b0;
    cmd            = CMD_PUSH;
    push_word      = '0;
    lost_count     = 0;
    shadow_fill    = 0;
    sender_idles   = 1'b1;
    receiver_idles = 1'b1;
    hold_cycles    = 0;
    repeat (9) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;

    test_directed();
    test_fill_and_drain();
    sender_idles   = 1'b0;
    receiver_idles = 1'b0;
    test_fill_and_drain();
    sender_idles   = 1'b1;
    receiver_idles = 1'b1;
    test_backpressure();
    test_random_walk(1300);

    wait_drained();
    repeat (8) @(posedge clk);
    if (fail_count == 0 && lost_count == 0) begin
      $display("** bounded_lifo_stack_top: PASSED **");
    end else begin
      $display("** bounded_lifo_stack_top: FAILED **");
    end
    $finish;
  end

  // Watchdog for a hung handshake.
  initial begin
    #8_000_000;
    $display("** bounded_lifo_stack_top: FAILED **");
    $finish;
  end

endmodule
